/* rtl/fcq_pkg.sv */
// Shared types and constants for the frustum culling query block.
package fcq_pkg;

  localparam int PLANE_COUNT      = 6;
  localparam int CLIP_PLANES_DEF  = 6;
  localparam int TEST_PLANES_DEF  = 6;
  localparam int FRAC_BITS        = 14;
  localparam int COORD_W          = 16;
  localparam int RADIUS_W         = 15;
  localparam int AXES             = 3;
  localparam int PLANE_W          = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int IN_DATA_W        = 112;
  localparam int OUT_DATA_W       = 8;

  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_BOX    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REL_OUTSIDE   = 2'd0,
    REL_INSIDE    = 2'd1,
    REL_INTERSECT = 2'd2
  } rel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    PLANE_LEFT   = 3'd0,
    PLANE_RIGHT  = 3'd1,
    PLANE_BOTTOM = 3'd2,
    PLANE_TOP    = 3'd3,
    PLANE_NEAR   = 3'd4,
    PLANE_FAR    = 3'd5
  } plane_idx_e;

endpackage

/* rtl/frustum_cull_query.sv */
// Frustum culling query: tests a point, sphere or box against six clip planes.
// Stages A to E are registered; the six plane lanes run in parallel.
// One request is accepted every cycle while the output is not stalled.
// A stalled output holds its result and the stages behind it close up bubbles.
// Reset clears all valid bits and sets every plane register to zero.
module frustum_cull_query #(
  parameter int CLIP_PLANES = fcq_pkg::CLIP_PLANES_DEF,
  parameter int TEST_PLANES = fcq_pkg::TEST_PLANES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, radius, zero pad
  input  logic [fcq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // relation, zero pad
  output logic [fcq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [fcq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcq_pkg::PLANE_W-1:0]    cfg_data_i
);
  import fcq_pkg::*;

  localparam logic [PLANE_COUNT-1:0] CLIP_MASK = PLANE_COUNT'((1 << CLIP_PLANES) - 1);
  localparam logic [PLANE_COUNT-1:0] TEST_MASK = PLANE_COUNT'((1 << TEST_PLANES) - 1);

  logic [PLANE_W-1:0] plane_q [PLANE_COUNT];

  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic en_a, en_b, en_c, en_d, en_e;

  cmd_e a_cmd_q, b_cmd_q, c_cmd_q, d_cmd_q;
  logic signed [COORD_W-1:0] a_lo_q [AXES];
  logic signed [COORD_W-1:0] a_hi_q [AXES];
  logic [RADIUS_W-1:0]       a_rad_q;

  logic signed [31:0] b_pp_d [PLANE_COUNT][AXES];
  logic signed [31:0] b_pn_d [PLANE_COUNT][AXES];
  logic signed [31:0] b_op_d [PLANE_COUNT];
  logic signed [31:0] b_on_d [PLANE_COUNT];
  logic signed [31:0] b_pp_q [PLANE_COUNT][AXES];
  logic signed [31:0] b_pn_q [PLANE_COUNT][AXES];
  logic signed [31:0] b_op_q [PLANE_COUNT];
  logic signed [31:0] b_on_q [PLANE_COUNT];

  logic signed [32:0] c_ap_d [PLANE_COUNT];
  logic signed [32:0] c_bp_d [PLANE_COUNT];
  logic signed [32:0] c_an_d [PLANE_COUNT];
  logic signed [32:0] c_bn_d [PLANE_COUNT];
  logic signed [32:0] c_ap_q [PLANE_COUNT];
  logic signed [32:0] c_bp_q [PLANE_COUNT];
  logic signed [32:0] c_an_q [PLANE_COUNT];
  logic signed [32:0] c_bn_q [PLANE_COUNT];

  logic [PLANE_COUNT-1:0] d_negp_d, d_npn_d, d_negp_q, d_npn_q;
  rel_e e_rel_d, e_rel_q;

  // Handshake: each stage moves when it is empty or the one after it moves.
  assign en_e = !e_v_q || m_axis_tready;
  assign en_d = !d_v_q || en_e;
  assign en_c = !c_v_q || en_d;
  assign en_b = !b_v_q || en_c;
  assign en_a = !a_v_q || en_b;

  assign s_axis_tready = en_a;
  assign m_axis_tvalid = e_v_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, e_rel_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_we_i && cfg_idx_i <= PLANE_FAR) begin
      plane_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= s_axis_tvalid;
      if (en_b) b_v_q <= a_v_q;
      if (en_c) c_v_q <= b_v_q;
      if (en_d) d_v_q <= c_v_q;
      if (en_e) e_v_q <= d_v_q;
    end
  end

  // Stage A: request capture.
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_cmd_q   <= cmd_e'(s_axis_tuser);
      for (int k = 0; k < AXES; k++) begin
        a_lo_q[k] <= s_axis_tdata[COORD_W*k +: COORD_W];
        a_hi_q[k] <= s_axis_tdata[COORD_W*(k+AXES) +: COORD_W];
      end
      a_rad_q   <= s_axis_tdata[COORD_W*2*AXES +: RADIUS_W];
    end
  end

  // Stage B: corner selection and products, one lane per plane.
  always_comb begin
    logic signed [COORD_W-1:0] comp;
    logic signed [COORD_W-1:0] pv;
    logic signed [COORD_W-1:0] nv;
    logic signed [31:0]        rad_s;
    logic                      is_box;
    is_box = (a_cmd_q == CMD_BOX);
    rad_s  = (a_cmd_q == CMD_SPHERE) ? ($signed(32'(a_rad_q)) <<< FRAC_BITS) : '0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      for (int k = 0; k < AXES; k++) begin
        comp = plane_q[i][COORD_W*k +: COORD_W];
        if (!is_box) begin
          pv = a_lo_q[k];
          nv = a_lo_q[k];
        end else if (comp >= 0) begin
          pv = a_hi_q[k];
          nv = a_lo_q[k];
        end else begin
          pv = a_lo_q[k];
          nv = a_hi_q[k];
        end
        b_pp_d[i][k] = comp * pv;
        b_pn_d[i][k] = comp * nv;
      end
      b_op_d[i] = 32'(signed'(plane_q[i][COORD_W*AXES +: COORD_W])) <<< FRAC_BITS;
      b_on_d[i] = b_op_d[i] + rad_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_cmd_q <= a_cmd_q;
      b_pp_q  <= b_pp_d;
      b_pn_q  <= b_pn_d;
      b_op_q  <= b_op_d;
      b_on_q  <= b_on_d;
    end
  end

  // Stage C: partial sums.
  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      c_ap_d[i] = 33'(b_pp_q[i][0]) + 33'(b_pp_q[i][1]);
      c_bp_d[i] = 33'(b_pp_q[i][2]) + 33'(b_op_q[i]);
      c_an_d[i] = 33'(b_pn_q[i][0]) + 33'(b_pn_q[i][1]);
      c_bn_d[i] = 33'(b_pn_q[i][2]) + 33'(b_on_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c_cmd_q <= b_cmd_q;
      c_ap_q  <= c_ap_d;
      c_bp_q  <= c_bp_d;
      c_an_q  <= c_an_d;
      c_bn_q  <= c_bn_d;
    end
  end

  // Stage D: final distances and per-plane sign flags.
  always_comb begin
    logic signed [33:0]     dist_p;
    logic signed [33:0]     dist_n;
    logic [PLANE_COUNT-1:0] lane_on;
    lane_on = (c_cmd_q == CMD_BOX) ? CLIP_MASK : TEST_MASK;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      dist_p      = 34'(c_ap_q[i]) + 34'(c_bp_q[i]);
      dist_n      = 34'(c_an_q[i]) + 34'(c_bn_q[i]);
      d_negp_d[i] = lane_on[i] && (dist_p < 0);
      d_npn_d[i]  = lane_on[i] && (dist_n <= 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      d_cmd_q  <= c_cmd_q;
      d_negp_q <= d_negp_d;
      d_npn_q  <= d_npn_d;
    end
  end

  // Stage E: classification into the output register.
  always_comb begin
    case (d_cmd_q)
      CMD_POINT:  e_rel_d = (|d_negp_q) ? REL_OUTSIDE : REL_INSIDE;
      CMD_SPHERE: e_rel_d = (|d_npn_q) ? REL_OUTSIDE : REL_INSIDE;
      CMD_BOX: begin
        if (|d_negp_q) e_rel_d = REL_OUTSIDE;
        else if (|d_npn_q) e_rel_d = REL_INTERSECT;
        else e_rel_d = REL_INSIDE;
      end
      default: e_rel_d = REL_OUTSIDE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      e_rel_q <= e_rel_d;
    end
  end

endmodule

/* rtl/fcq_checker.sv */
// Port-level checker for the frustum culling query block, with its bind.
module fcq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fcq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import fcq_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_acc, 5) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2) &&
    $past(m_axis_tready, 3) && $past(m_axis_tready, 4) && $past(rst_ni, 1) &&
    $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4) && $past(rst_ni, 5)
    |-> m_axis_tvalid)
    else $error("result missing five cycles after request");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[OUT_DATA_W-1:2] == '0)
    else $error("bad relation code");

endmodule

bind frustum_cull_query fcq_checker u_fcq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
